// ----- sv/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and transfer types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int OPCODE_W   = 2;
  localparam int POSITION_W = 7;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (POSITION_W > CNT_W) ? POSITION_W : CNT_W;

  localparam int GROUP_SIZE = 8;
  localparam int GRP_W      = $clog2(GROUP_SIZE);
  localparam int N_GROUPS   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NG_W       = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [POSITION_W-1:0]   position;
    logic [WORD_W-1:0]       data_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]       data_out;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } out_item_t;

  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic [IDX_W-1:0]        pos;
    logic [DATA_WIDTH-1:0]   data;
  } shift_ctl_t;

endpackage

// ----- sv/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// One list entry. Takes its left neighbor on an insert below it, the new word
// on an insert at its place, and its right neighbor on a remove at or below it.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                          clk,
  input  ple_pkg::shift_ctl_t           ctl,
  input  logic [ple_pkg::IDX_W-1:0]     my_idx,
  input  logic [ple_pkg::DATA_WIDTH-1:0] left_word,
  input  logic [ple_pkg::DATA_WIDTH-1:0] right_word,
  output logic [ple_pkg::DATA_WIDTH-1:0] word
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (my_idx > ctl.pos) begin
        word_nxt = left_word;
      end else if (my_idx == ctl.pos) begin
        word_nxt = ctl.data;
      end
    end else if (ctl.rem && (my_idx >= ctl.pos)) begin
      word_nxt = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- sv/ple_rd_group.sv -----
// ----------------------------------------------------------------------------
// ple_rd_group
// First level of the read select: picks one word of a group of cells and
// registers it.
// ----------------------------------------------------------------------------
module ple_rd_group (
  input  logic                           clk,
  input  logic                           en,
  input  logic [ple_pkg::GRP_W-1:0]      sel,
  input  logic [ple_pkg::DATA_WIDTH-1:0] words [ple_pkg::GROUP_SIZE],
  output logic [ple_pkg::DATA_WIDTH-1:0] word_r
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = en ? words[sel] : word_r;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ----- sv/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of words with get, insert and remove by position.
// ----------------------------------------------------------------------------
// The list lives in a row of cells that all shift in the same cycle, so a
// request is taken in every cycle unless the output is held back while a
// result already waits in the first level. Its result passes through the
// read select registers: the first level registers at the transfer itself
// and the second level is the output register. While a result waits, one
// more request can be taken before the input stalls. Errors leave the list unchanged.
module positional_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ple_pkg::out_item_t out_data
);
  import ple_pkg::*;

  logic                  accept;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  rd_ok;
  logic                  ins_ok;
  logic                  rem_ok;
  status_t               status_c;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;
  logic [IDX_W-1:0]      pos_idx;
  shift_ctl_t            ctl;

  logic [DATA_WIDTH-1:0] words   [CAPACITY];
  logic [DATA_WIDTH-1:0] grp_in  [N_GROUPS][GROUP_SIZE];
  logic [DATA_WIDTH-1:0] grp_r   [N_GROUPS];

  logic                  s1_vld_r;
  logic                  s1_rd_r;
  status_t               s1_status_r;
  logic [COUNT_W-1:0]    s1_count_r;
  logic [NG_W-1:0]       s1_gsel_r;

  logic                  out_vld_r;
  out_item_t             out_data_r;
  logic [DATA_WIDTH-1:0] sel_word;

  assign out_free = !out_vld_r || out_ready;
  assign in_ready = rst_n && (!s1_vld_r || out_free);
  assign accept   = in_valid && in_ready;

  assign pos_c   = CMP_W'(in_data.position);
  assign cnt_c   = CMP_W'(cnt_r);
  assign pos_idx = IDX_W'(in_data.position);

  always_comb begin
    rd_ok    = 1'b0;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    status_c = ST_OK;
    case (in_data.opcode)
      OP_GET: begin
        if (pos_c < cnt_c) begin
          rd_ok = 1'b1;
        end else begin
          status_c = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          status_c = ST_RANGE;
        end else if (cnt_r == CNT_W'(CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_c < cnt_c) begin
          rd_ok  = 1'b1;
          rem_ok = 1'b1;
        end else begin
          status_c = ST_RANGE;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (accept && rem_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign ctl.ins  = accept && ins_ok;
  assign ctl.rem  = accept && rem_ok;
  assign ctl.pos  = pos_idx;
  assign ctl.data = DATA_WIDTH'(in_data.data_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_body
      assign right_w = words[i+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .my_idx     (IDX_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i])
    );
  end

  for (genvar g = 0; g < N_GROUPS; g++) begin : g_grp
    for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_tap
      if (g * GROUP_SIZE + k < CAPACITY) begin : g_used
        assign grp_in[g][k] = words[g*GROUP_SIZE+k];
      end else begin : g_pad
        assign grp_in[g][k] = '0;
      end
    end
    ple_rd_group u_grp (
      .clk    (clk),
      .en     (accept),
      .sel    (GRP_W'(pos_idx)),
      .words  (grp_in[g]),
      .word_r (grp_r[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (out_free) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r     <= rd_ok;
      s1_status_r <= status_c;
      s1_count_r  <= COUNT_W'(cnt_nxt);
      s1_gsel_r   <= NG_W'(pos_idx >> GRP_W);
    end
  end

  assign sel_word = s1_rd_r ? grp_r[s1_gsel_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_vld_r && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && out_free) begin
      out_data_r.data_out <= WORD_W'(sel_word);
      out_data_r.status   <= s1_status_r;
      out_data_r.count    <= s1_count_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ins_ok) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not raise the count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && (s1_status_r == ST_FULL)) |-> (s1_count_r == COUNT_W'(CAPACITY)))
    else $error("full status with a count below capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.status != ST_OK)) |-> (out_data_r.data_out == '0))
    else $error("error result carries data");

endmodule
